### src/plrs_pkg.sv
// Shared types, request codes and saturating arithmetic for the per-label
// region statistics block. No dependencies.
package plrs_pkg;

  typedef enum logic [1:0] {
    REQ_ACC   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    CFG_NUM_COMP = 2'd0,
    CFG_AREA_EN  = 2'd1,
    CFG_VOL_EN   = 2'd2,
    CFG_SPARE    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0]        cnt;
    logic signed [55:0] sx;
    logic signed [55:0] sy;
    logic signed [55:0] sz;
    logic [55:0]        ar;
    logic [55:0]        vo;
    logic signed [55:0] vs;
    logic signed [55:0] ws;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic rd_en;
    logic wr_en;
  } tbl_ctrl_t;

  localparam logic signed [57:0] S56_MAX = 58'sh007FFFFFFFFFFFFF;
  localparam logic signed [57:0] S56_MIN = -58'sh0080000000000000;

  function automatic logic signed [55:0] add_s56(logic signed [55:0] a,
                                                logic signed [57:0] d);
    logic signed [57:0] s;
    s = 58'(a) + d;
    if (s > S56_MAX) return 56'(S56_MAX);
    if (s < S56_MIN) return 56'(S56_MIN);
    return s[55:0];
  endfunction

  function automatic logic [55:0] add_u56(logic [55:0] a, logic [31:0] d);
    logic [56:0] s;
    s = {1'b0, a} + {25'b0, d};
    if (s[56]) return '1;
    return s[55:0];
  endfunction

endpackage

### src/plrs_table.sv
// Accumulator table: one synchronous memory of entries with a registered read
// and per-entry valid bits so that reset and clear act at once. Uses plrs_pkg.
module plrs_table import plrs_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tbl_ctrl_t     ctrl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  output entry_t        rd_data
);

  entry_t           mem [DEPTH];
  entry_t           rd_q_r;
  logic             rd_vld_r;
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### src/plrs_div.sv
// Bit-serial signed divider: 56-bit sum by 32-bit count, truncating toward
// zero and saturating to 32 bits. One quotient bit per cycle. Uses plrs_pkg.
module plrs_div import plrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [55:0] dividend,
  input  logic [31:0]        divisor,
  output logic               busy,
  output logic signed [31:0] quotient
);

  logic [32:0] rem_r, rem_nxt;
  logic [55:0] quo_r, quo_nxt;
  logic [31:0] dsr_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, busy_r, busy_nxt;
  logic [32:0] rem_sh;
  logic [31:0] neg_q;

  always_comb begin
    rem_sh   = {rem_r[31:0], quo_r[55]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sh - {1'b0, dsr_r};
        quo_nxt = {quo_r[54:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[54:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd56;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[55] ? 56'(-dividend) : dividend;
      dsr_r <= divisor;
      neg_r <= dividend[55];
    end else begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign neg_q = 32'(-quo_r[31:0]);

  always_comb begin
    if (!neg_r) begin
      quotient = (quo_r > 56'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_r[31:0];
    end else begin
      quotient = (quo_r > 56'h80000000) ? 32'sh80000000 : neg_q;
    end
  end

  assign busy = busy_r;

endmodule

### src/per_label_region_statistics.sv
// Per-label region statistics: request stream in, component report out.
// Uses plrs_pkg, plrs_table and plrs_div.
//
// Requests arrive on in_tvalid/in_tready with the request kind in in_tuser
// (0 accumulate, 1 read, 2 clear). The block handles one request at a time.
// An accumulate does a table read, a multiply of value by weight, then a
// saturating update and write back into the single table memory. A clear
// drops the valid bits of every entry. A read raises out_tvalid once the
// three bit-serial dividers that form the centroid have finished.
// Results leave through an output register on out_tvalid/out_tready; the
// block keeps taking requests while a report waits, and a later read holds
// in its last step until the receiver takes the pending report.
// Configuration writes on cfg_valid/cfg_ready are always taken, and must
// come only while the block is idle.
// Synchronous active-low reset empties the table at once and restores the
// register defaults (256 components, area off, volume on).
module per_label_region_statistics import plrs_pkg::*; #(
  parameter int MAX_COMPONENTS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tuser: req_type[1:0]
  input  logic [1:0]   in_tuser,
  // tdata: cell_label[7:0], center_x[39:8], center_y[71:40],
  // center_z[103:72], cell_value[135:104], cell_area[167:136],
  // cell_volume[199:168]
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: component_label[7:0], cell_count[39:8], centroid_x[71:40],
  // centroid_y[103:72], centroid_z[135:104], area_total[191:136],
  // volume_total[247:192], value_sum[303:248], weighted_sum[359:304]
  output logic [359:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_data
);

  localparam int DEPTH = (MAX_COMPONENTS < 256) ? MAX_COMPONENTS : 256;
  localparam int AW = $clog2(DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(DEPTH);

  state_t state_r, state_nxt;
  logic [8:0] num_comp_r;
  logic       area_en_r, vol_en_r;

  logic [1:0]         req_r;
  logic [7:0]         label_r;
  logic signed [31:0] cx_r, cy_r, cz_r, val_r;
  logic [31:0]        area_r, vol_r;
  logic signed [63:0] prod_r;
  entry_t             ent_r, rd_data, upd;
  tbl_ctrl_t          ctrl;
  logic               in_acc, in_range, div_start, load_out;
  logic [7:0]         in_label;
  logic [31:0]        weight;
  logic               busy_x, busy_y, busy_z;
  logic signed [31:0] q_x, q_y, q_z;
  logic               out_tvalid_r;
  logic [359:0]       out_tdata_r;
  logic [31:0]        cen_x, cen_y, cen_z;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign in_label  = in_tdata[7:0];
  assign in_range  = ({1'b0, in_label} < num_comp_r) && ({1'b0, in_label} < DEPTH9);
  assign weight    = vol_en_r ? vol_r : (area_en_r ? area_r : 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_comp_r <= 9'd256;
      area_en_r  <= 1'b0;
      vol_en_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_COMP: num_comp_r <= cfg_data;
        CFG_AREA_EN:  area_en_r  <= cfg_data[0];
        CFG_VOL_EN:   vol_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    ctrl       = '0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          if (in_tuser == REQ_CLEAR) begin
            ctrl.clr = 1'b1;
          end else if ((in_tuser inside {REQ_ACC, REQ_READ}) && in_range) begin
            ctrl.rd_en = 1'b1;
            state_nxt  = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (req_r == REQ_ACC) begin
          state_nxt = ST_UPD;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_UPD: begin
        ctrl.wr_en = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_DIV: begin
        if (!busy_x && !busy_y && !busy_z) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r   <= in_tuser;
      label_r <= in_label;
      cx_r    <= in_tdata[39:8];
      cy_r    <= in_tdata[71:40];
      cz_r    <= in_tdata[103:72];
      val_r   <= in_tdata[135:104];
      area_r  <= in_tdata[167:136];
      vol_r   <= in_tdata[199:168];
    end
    if (state_r == ST_LOOK) begin
      ent_r  <= rd_data;
      prod_r <= val_r * $signed({1'b0, weight});
    end
  end

  always_comb begin
    upd    = ent_r;
    upd.cnt = (ent_r.cnt == 32'hFFFFFFFF) ? ent_r.cnt : ent_r.cnt + 32'd1;
    upd.sx = add_s56(ent_r.sx, 58'(cx_r));
    upd.sy = add_s56(ent_r.sy, 58'(cy_r));
    upd.sz = add_s56(ent_r.sz, 58'(cz_r));
    upd.vs = add_s56(ent_r.vs, 58'(val_r));
    upd.ws = add_s56(ent_r.ws, 58'(prod_r >>> 16));
    if (area_en_r) begin
      upd.ar = add_u56(ent_r.ar, area_r);
    end
    if (vol_en_r) begin
      upd.vo = add_u56(ent_r.vo, vol_r);
    end
  end

  plrs_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_addr (in_label[AW-1:0]),
    .wr_addr (label_r[AW-1:0]),
    .wr_data (upd),
    .rd_data (rd_data)
  );

  plrs_div u_div_x (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(rd_data.sx),
                    .divisor(rd_data.cnt), .busy(busy_x), .quotient(q_x));
  plrs_div u_div_y (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(rd_data.sy),
                    .divisor(rd_data.cnt), .busy(busy_y), .quotient(q_y));
  plrs_div u_div_z (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(rd_data.sz),
                    .divisor(rd_data.cnt), .busy(busy_z), .quotient(q_z));

  assign cen_x = (ent_r.cnt == 32'd0) ? 32'd0 : q_x;
  assign cen_y = (ent_r.cnt == 32'd0) ? 32'd0 : q_y;
  assign cen_z = (ent_r.cnt == 32'd0) ? 32'd0 : q_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {ent_r.ws, ent_r.vs,
                      vol_en_r ? ent_r.vo : 56'd0,
                      area_en_r ? ent_r.ar : 56'd0,
                      cen_z, cen_y, cen_x, ent_r.cnt, label_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_wr_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en |-> $past(state_r) == ST_LOOK && req_r == REQ_ACC)
    else $error("table write without a preceding lookup");

  a_div_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> req_r == REQ_READ)
    else $error("divide phase entered for a non-read request");

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_OUT)
    else $error("report raised outside the output step");

  a_div_done_together: assert property (@(posedge clk) disable iff (!rst_n)
    busy_x == busy_y && busy_y == busy_z)
    else $error("centroid dividers out of step");

endmodule
